[design/fca_pkg.sv]
// ----------------------------------------------------------------------------
// FAT chain allocator package
// Shared types, codes and fixed widths for the allocation table block.
// ----------------------------------------------------------------------------
package fca_pkg;

  // Fixed field widths
  localparam int BLOCK_W         = 11;
  localparam int COUNT_W         = 12;
  localparam int KIND_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int TAG_W           = 2;

  // Table layout and count limits
  localparam int FIRST_DATA      = 2;
  localparam int MIN_COUNT       = 3;
  localparam int BLOCK_COUNT_RST = 2048;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Request operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_FORMAT     = 3'd0,
    KIND_ALLOC      = 3'd1,
    KIND_FREE_CHAIN = 3'd2,
    KIND_FIND_LAST  = 3'd3,
    KIND_READ_NEXT  = 3'd4
  } fca_kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_BAD_CHAIN = 2'd2,
    STAT_RANGE     = 2'd3
  } fca_status_t;

  // Tag held in the top bits of every table entry
  typedef enum logic [TAG_W-1:0] {
    TAG_LINK = 2'd0,
    TAG_END  = 2'd1,
    TAG_FREE = 2'd2
  } fca_tag_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_LINK_CHK,
    ST_SCAN,
    ST_ALLOC_LINK,
    ST_WALK,
    ST_DONE
  } fca_state_t;

  // Request payload
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] block;
    logic               link_after;
  } fca_req_t;

  // Result payload
  typedef struct packed {
    logic [BLOCK_W-1:0] result_block;
    logic               at_end;
    fca_status_t        status;
    logic [COUNT_W-1:0] free_count;
  } fca_rsp_t;

endpackage

[design/fca_if.sv]
// ----------------------------------------------------------------------------
// FAT chain allocator channel interfaces
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface fca_req_if import fca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BLOCK_W-1:0] block;
  logic               link_after;

  modport source (output valid, output kind, output block, output link_after,
                  input ready);
  modport sink   (input valid, input kind, input block, input link_after,
                  output ready);
endinterface

interface fca_rsp_if import fca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BLOCK_W-1:0]  result_block;
  logic                at_end;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, output result_block, output at_end,
                  output status, output free_count, input ready);
  modport sink   (input valid, input result_block, input at_end,
                  input status, input free_count, output ready);
endinterface

[design/fca_ram.sv]
// ----------------------------------------------------------------------------
// FAT chain allocator RAM
// Generic single-write, single-read RAM with registered read data; a read
// of the address being written returns the new data.
// ----------------------------------------------------------------------------
module fca_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, new data on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/fca_ctrl.sv]
// ----------------------------------------------------------------------------
// FAT chain allocator sequencer
// Runs every operation as a sequence of single table accesses: sweeps for
// format and reset clearing, a linear free scan for allocate and one link per
// cycle for chain walks. Keeps the free total and a lowest-free hint.
// ----------------------------------------------------------------------------
module fca_ctrl import fca_pkg::*; #(
  parameter int NUM_BLOCKS = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fca_req_t                      req,
  input  logic [COUNT_W-1:0]            block_count,
  output logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
  input  logic [$clog2(NUM_BLOCKS)+1:0] rd_data,
  output logic                          wr_en,
  output logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
  output logic [$clog2(NUM_BLOCKS)+1:0] wr_data,
  input  logic                          out_free,
  output logic                          out_load,
  output fca_rsp_t                      rsp_data
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int EW = IW + TAG_W;
  localparam int CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam logic [CW-1:0] FIRST      = CW'(FIRST_DATA);
  localparam logic [CW-1:0] LOW_COUNT  = CW'(MIN_COUNT);
  localparam logic [CW-1:0] NB         = CW'(NUM_BLOCKS);
  localparam logic [CW-1:0] LAST_ENTRY = CW'(NUM_BLOCKS - 1);
  localparam logic [COUNT_W-1:0] RST_FREE = COUNT_W'(
    ((BLOCK_COUNT_RST < NUM_BLOCKS) ? BLOCK_COUNT_RST : NUM_BLOCKS) - FIRST_DATA);

  fca_state_t         state, state_next;
  fca_kind_t          kind_r;
  logic [CW-1:0]      blk_r;
  logic               link_r;
  logic [CW-1:0]      cur;
  logic [CW-1:0]      steps;
  logic [CW-1:0]      sa;
  logic               chk_valid;
  logic               clr_only;
  logic [COUNT_W-1:0] free_total;
  logic [CW-1:0]      hint;
  logic [BLOCK_W-1:0] res_block;
  logic               res_end;
  fca_status_t        res_status;

  logic [CW-1:0]      bc_w, eff, eff_free, req_blk, rd_link_c;
  fca_kind_t          req_kind;
  fca_tag_t           rd_tag;
  logic               is_free, is_end;
  logic               steps_over, cur_low, cur_over, sa_over, found;
  logic               blk_bad, blk_over, sweep_last;
  logic               walk_range, walk_fail, walk_end, walk_stop;
  fca_status_t        walk_fail_status;

  // Clamp the configured count to at least the minimum count and at most the table size
  always_comb begin
    bc_w = CW'(block_count);
    if (bc_w < LOW_COUNT) begin
      eff = LOW_COUNT;
    end else if (bc_w > NB) begin
      eff = NB;
    end else begin
      eff = bc_w;
    end
    eff_free = eff - FIRST;
  end

  // Decode request and table entry
  assign req_kind  = fca_kind_t'(req.kind);
  assign req_blk   = CW'(req.block);
  assign rd_tag    = fca_tag_t'(rd_data[EW-1 -: TAG_W]);
  assign rd_link_c = CW'(rd_data[IW-1:0]);
  assign is_free   = (rd_tag == TAG_FREE);
  assign is_end    = (rd_tag == TAG_END);

  // Shared compare unit
  always_comb begin
    steps_over = (steps >= eff);
    cur_low    = (cur < FIRST);
    cur_over   = (cur >= eff);
    sa_over    = (sa >= eff);
    found      = chk_valid && is_free;
    blk_over   = (req_blk >= eff);
    blk_bad    = (req_blk < FIRST) || blk_over;
    sweep_last = (sa == LAST_ENTRY);
    walk_range = (kind_r == KIND_FREE_CHAIN) ? (cur_low || cur_over) : cur_over;
    walk_fail  = steps_over || walk_range || is_free;
    walk_fail_status = (!steps_over && walk_range) ? STAT_RANGE : STAT_BAD_CHAIN;
    walk_end   = !walk_fail && is_end;
    walk_stop  = walk_fail || walk_end;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_next = clr_only ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          case (req_kind)
            KIND_FORMAT: state_next = ST_SWEEP;
            KIND_ALLOC: begin
              if (req.link_after && blk_bad) begin
                state_next = ST_DONE;
              end else if (req.link_after) begin
                state_next = ST_LINK_CHK;
              end else begin
                state_next = ST_SCAN;
              end
            end
            KIND_FREE_CHAIN, KIND_FIND_LAST: state_next = ST_WALK;
            KIND_READ_NEXT: state_next = blk_over ? ST_DONE : ST_READ;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_READ:       state_next = ST_DONE;
      ST_LINK_CHK:   state_next = is_free ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        if (found) begin
          state_next = link_r ? ST_ALLOC_LINK : ST_DONE;
        end else if (sa_over) begin
          state_next = ST_DONE;
        end
      end
      ST_ALLOC_LINK: state_next = ST_DONE;
      ST_WALK:       state_next = walk_stop ? ST_DONE : ST_WALK;
      ST_DONE:       state_next = out_free ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Handshake and table port outputs
  always_comb begin
    req_ready = (state == ST_IDLE);
    out_load  = (state == ST_DONE) && out_free;
    rd_addr   = req_blk[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cur[IW-1:0];
    wr_data   = {TAG_FREE, {IW{1'b0}}};
    case (state)
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sa[IW-1:0];
        wr_data = (sa < FIRST) ? {TAG_END, {IW{1'b0}}} : {TAG_FREE, {IW{1'b0}}};
      end
      ST_SCAN: begin
        rd_addr = sa[IW-1:0];
        wr_en   = found;
        wr_data = {TAG_END, {IW{1'b0}}};
      end
      ST_ALLOC_LINK: begin
        wr_en   = 1'b1;
        wr_addr = blk_r[IW-1:0];
        wr_data = {TAG_LINK, cur[IW-1:0]};
      end
      ST_WALK: begin
        rd_addr = rd_data[IW-1:0];
        wr_en   = (kind_r == KIND_FREE_CHAIN) && !walk_fail;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sa         <= '0;
      clr_only   <= 1'b1;
      chk_valid  <= 1'b0;
      free_total <= RST_FREE;
      hint       <= FIRST;
    end else begin
      state <= state_next;
      case (state)
        ST_SWEEP: begin
          if (!sweep_last) begin
            sa <= sa + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            kind_r     <= req_kind;
            blk_r      <= req_blk;
            link_r     <= req.link_after;
            cur        <= req_blk;
            steps      <= '0;
            sa         <= hint;
            chk_valid  <= 1'b0;
            res_block  <= '0;
            res_end    <= 1'b0;
            res_status <= STAT_OK;
            case (req_kind)
              KIND_FORMAT: begin
                sa         <= '0;
                clr_only   <= 1'b0;
                free_total <= eff_free[COUNT_W-1:0];
                hint       <= FIRST;
              end
              KIND_ALLOC: begin
                if (req.link_after && blk_bad) begin
                  res_status <= STAT_RANGE;
                end
              end
              KIND_READ_NEXT: begin
                if (blk_over) begin
                  res_status <= STAT_RANGE;
                end
              end
              default: begin
                res_status <= STAT_OK;
              end
            endcase
          end
        end
        ST_READ: begin
          case (rd_tag)
            TAG_FREE: res_status <= STAT_BAD_CHAIN;
            TAG_END:  res_end    <= 1'b1;
            default:  res_block  <= rd_link_c[BLOCK_W-1:0];
          endcase
        end
        ST_LINK_CHK: begin
          if (is_free) begin
            res_status <= STAT_BAD_CHAIN;
          end
        end
        ST_SCAN: begin
          // Check the entry read last cycle, issue the next address
          if (found) begin
            free_total <= (free_total == '0) ? free_total : free_total - 1'b1;
            hint       <= cur + 1'b1;
            res_block  <= cur[BLOCK_W-1:0];
          end else if (sa_over) begin
            res_status <= STAT_NO_SPACE;
            hint       <= sa;
          end else begin
            cur       <= sa;
            chk_valid <= 1'b1;
            sa        <= sa + 1'b1;
          end
        end
        ST_WALK: begin
          if (walk_fail) begin
            res_status <= walk_fail_status;
          end else if (kind_r == KIND_FREE_CHAIN) begin
            free_total <= (free_total == COUNT_MAX) ? free_total : free_total + 1'b1;
            if (cur < hint) begin
              hint <= cur;
            end
          end
          if (walk_end && (kind_r == KIND_FIND_LAST)) begin
            res_block <= cur[BLOCK_W-1:0];
          end
          // Follow the link
          if (!walk_stop) begin
            cur   <= rd_link_c;
            steps <= steps + 1'b1;
          end
        end
        default: begin
          chk_valid <= chk_valid;
        end
      endcase
    end
  end

  assign rsp_data = '{result_block: res_block, at_end: res_end,
                      status: res_status, free_count: free_total};

  // Chain freeing only ever writes free entries
  a_walk_writes_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && wr_en) |-> (wr_data[EW-1 -: TAG_W] == TAG_FREE))
    else $error("chain walk wrote a non-free entry");

  // Each allocation takes one block off the free total unless it is already zero
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && wr_en) |=>
      (free_total == $past(free_total) - 1'b1) || ($past(free_total) == '0))
    else $error("free total not decremented on allocation");

  // Linking follows a successful scan of a linked allocation
  a_link_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC_LINK) |-> ($past(state) == ST_SCAN) && link_r)
    else $error("link write outside a linked allocation");

  // Lowest-free hint never points into the reserved entries
  a_hint_floor: assert property (@(posedge clk) disable iff (rst)
    hint >= FIRST)
    else $error("free hint below first data block");

endmodule

[design/fat_chain_allocator.sv]
// ----------------------------------------------------------------------------
// FAT chain allocator
// Keeps a table of next-block links with format, allocate, free chain, find
// last and read next operations, and a running free count.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  req      | in  | valid / ready      | kind, block, link_after
//  rsp      | out | valid / ready      | result_block, at_end, status, free_count
//  cfg      | in  | cfg_wr_en          | cfg_wr_data (block_count)
//
//  One request at a time. Format sweeps all NUM_BLOCKS entries; allocate
//  scans one entry a cycle from the lowest possibly free block; chain walks
//  follow one link a cycle through the single table read port. After reset
//  a clearing pass over all NUM_BLOCKS entries runs before req is ready.
//  A finished result waits in the output register while the next request
//  is taken; the sequencer stalls at completion only if that register is full.
// ----------------------------------------------------------------------------
module fat_chain_allocator import fca_pkg::*; #(
  parameter int NUM_BLOCKS = 2048
) (
  input  logic               clk,
  input  logic               rst,
  fca_req_if.sink            req,
  fca_rsp_if.source          rsp,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int EW = IW + TAG_W;

  logic [COUNT_W-1:0] block_count;
  logic               rsp_valid;
  fca_rsp_t           rsp_q;
  fca_req_t           req_s;
  fca_rsp_t           res;
  logic               out_free, out_load;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic [EW-1:0]      rd_data, wr_data;
  logic               wr_en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= COUNT_W'(BLOCK_COUNT_RST);
    end else if (cfg_wr_en) begin
      block_count <= cfg_wr_data;
    end
  end

  assign req_s = '{kind: req.kind, block: req.block, link_after: req.link_after};

  fca_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fca_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req         (req_s),
    .block_count (block_count),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_free    (out_free),
    .out_load    (out_load),
    .rsp_data    (res)
  );

  // Output register: load a finished result, drop it once taken
  assign out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.result_block = rsp_q.result_block;
  assign rsp.at_end       = rsp_q.at_end;
  assign rsp.status       = rsp_q.status;
  assign rsp.free_count   = rsp_q.free_count;

endmodule
